>>> sv/deadline_timer_table_macros.svh
// Assertion macros for the deadline timer table.
`ifndef DEADLINE_TIMER_TABLE_MACROS_SVH
`define DEADLINE_TIMER_TABLE_MACROS_SVH
// Implication checked on every clock unless reset is high.
`define DTT_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked unless reset is high.
`define DTT_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

>>> sv/dtt_pkg.sv
// Package of types and constants for the deadline timer table.
package dtt_pkg;
   localparam int NumSlots   = 16;
   localparam int SlotBits   = 4;
   localparam int TimeBits   = 48;
   localparam int PeriodBits = 32;
   localparam int MaxResults = 16;

   typedef logic [TimeBits-1:0]   time_type;
   typedef logic [PeriodBits-1:0] period_type;
   typedef logic [SlotBits-1:0]   slot_type;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_CANCEL  = 3'd1,
      OP_REFRESH = 3'd2,
      OP_RESET   = 3'd3,
      OP_TICK    = 3'd4,
      OP_QUERY   = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FAIL    = 2'd1,
      ST_EXPIRED = 2'd2,
      ST_NONE    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_MOD_RD,
      S_MOD_WR,
      S_TSEL,
      S_TRD,
      S_TOUT,
      S_RESP
   } state_type;
endpackage

>>> sv/deadline_timer_table.sv
// Deadline timer table: slot memory, time counter and scanning sequencer.
//  channel | ports                                              | dir
//  req     | req_valid req_stall req_opcode req_slot_select ... | in
//  rsp     | rsp_valid rsp_stall rsp_status rsp_slot_id ...     | out
// Query and a tick with nothing due scan all slots through the memory read port;
// each expired slot adds a rescan. Add goes straight to the write state; cancel,
// refresh and reset first pass through a memory read state.
// Synchronous reset clears the active and repeat bits and the time counter.
// A stalled result holds the sequencer where it would output and stalls requests; one item is in work at a time.
`include "deadline_timer_table_macros.svh"
module deadline_timer_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_opcode,
   input  logic [3:0]                   req_slot_select,
   input  logic [31:0]                  req_period_ms,
   input  logic                         req_repeating,
   input  logic                         req_restart_from_now,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [3:0]                   rsp_slot_id,
   output logic [47:0]                  rsp_wait_ms,
   output logic                         rsp_last_item
);
   import dtt_pkg::*;

   localparam int CntBits = SlotBits + 1;

   period_type mem_period [NumSlots];
   time_type   mem_deadline [NumSlots];

   logic [NumSlots-1:0] active_ff, active_in, cyclic_ff, cyclic_in;
   logic [NumSlots-1:0] taken_ff, taken_in;
   time_type   now_ff, now_in;
   state_type  state_ff, state_in;
   logic [2:0] op_ff, op_in;
   slot_type   sel_ff, sel_in;
   period_type per_ff, per_in;
   logic       rep_ff, rep_in, fnow_ff, fnow_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic [CntBits-1:0] nres_ff, nres_in;
   logic       best_ok_ff, best_ok_in;
   slot_type   best_ff, best_in;
   time_type   bestd_ff, bestd_in;
   slot_type   prev_ff, prev_in;

   logic       rv_ff, rv_in;
   logic [1:0] rst_ff, rst_in;
   slot_type   rid_ff, rid_in;
   time_type   rwait_ff, rwait_in;
   logic       rlast_ff, rlast_in;

   slot_type   rd_addr;
   period_type rd_period;
   time_type   rd_deadline;
   logic       wr_en;
   slot_type   wr_addr;
   period_type wr_period;
   time_type   wr_deadline;
   logic       wr_per_en;

   always_ff @(posedge clock) begin
      rd_period   <= mem_period[rd_addr];
      rd_deadline <= mem_deadline[rd_addr];
      if (wr_en) begin
         mem_deadline[wr_addr] <= wr_deadline;
         if (wr_per_en) begin
            mem_period[wr_addr] <= wr_period;
         end
      end
   end

   slot_type   scan_idx;
   logic       cand;
   time_type   shift_d;
   logic       out_free;

   assign scan_idx = SlotBits'(cnt_ff - CntBits'(1));
   assign out_free = !rv_ff || !rsp_stall;

   always_comb begin
      if (per_ff >= rd_period) begin
         shift_d = rd_deadline + TimeBits'(per_ff - rd_period);
      end else if (rd_deadline >= TimeBits'(rd_period - per_ff)) begin
         shift_d = rd_deadline - TimeBits'(rd_period - per_ff);
      end else begin
         shift_d = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      active_in = active_ff; cyclic_in = cyclic_ff; taken_in = taken_ff;
      now_in = now_ff; op_in = op_ff; sel_in = sel_ff; per_in = per_ff;
      rep_in = rep_ff; fnow_in = fnow_ff; cnt_in = cnt_ff; nres_in = nres_ff;
      best_ok_in = best_ok_ff; best_in = best_ff; bestd_in = bestd_ff;
      prev_in = prev_ff;
      rv_in = rv_ff && rsp_stall; rst_in = rst_ff; rid_in = rid_ff;
      rwait_in = rwait_ff; rlast_in = rlast_ff;
      rd_addr = '0; wr_en = 1'b0; wr_addr = sel_ff; wr_period = per_ff;
      wr_deadline = now_ff + TimeBits'(per_ff); wr_per_en = 1'b0;
      req_stall = 1'b1; cand = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               op_in = req_opcode; sel_in = req_slot_select; per_in = req_period_ms;
               rep_in = req_repeating; fnow_in = req_restart_from_now;
               cnt_in = '0; nres_in = '0; best_ok_in = 1'b0; taken_in = '0;
               if (req_opcode == OP_TICK) begin
                  now_in = now_ff + TimeBits'(1);
                  state_in = S_SCAN;
               end else if (req_opcode == OP_QUERY) begin
                  state_in = S_SCAN;
               end else if (req_opcode == OP_ADD) begin
                  state_in = S_MOD_WR;
               end else if (req_opcode == OP_CANCEL || req_opcode == OP_REFRESH ||
                            req_opcode == OP_RESET) begin
                  state_in = S_MOD_RD;
               end else begin
                  rst_in = ST_FAIL; rid_in = '0; rwait_in = '0; rlast_in = 1'b1;
                  state_in = S_RESP;
               end
            end
         end
         S_MOD_RD: begin
            rd_addr = sel_ff;
            state_in = S_MOD_WR;
         end
         S_MOD_WR: begin
            rid_in = '0; rwait_in = '0; rlast_in = 1'b1; rst_in = ST_OK;
            if (op_ff == OP_ADD) begin
               rst_in = ST_FAIL;
               for (int i = NumSlots - 1; i >= 0; i--) begin
                  if (!active_ff[i]) begin
                     rst_in = ST_OK; rid_in = SlotBits'(i);
                  end
               end
               if (rst_in == ST_OK) begin
                  wr_en = 1'b1; wr_per_en = 1'b1; wr_addr = rid_in;
                  active_in[rid_in] = 1'b1; cyclic_in[rid_in] = rep_ff;
               end
            end else if (!active_ff[sel_ff]) begin
               rst_in = ST_FAIL;
            end else if (op_ff == OP_CANCEL) begin
               active_in[sel_ff] = 1'b0;
            end else if (op_ff == OP_REFRESH) begin
               wr_en = 1'b1; wr_period = rd_period;
               wr_deadline = now_ff + TimeBits'(rd_period);
            end else begin
               wr_en = 1'b1; wr_per_en = 1'b1;
               if (!fnow_ff) begin
                  wr_deadline = shift_d;
               end
            end
            state_in = S_RESP;
         end
         S_SCAN: begin
            rd_addr = SlotBits'(cnt_ff);
            if (cnt_ff != '0) begin
               cand = active_ff[scan_idx] && !taken_ff[scan_idx];
               if (op_ff == OP_TICK) begin
                  cand = cand && rd_deadline <= now_ff;
               end
               if (cand && (!best_ok_in || rd_deadline < bestd_ff)) begin
                  best_ok_in = 1'b1; best_in = scan_idx; bestd_in = rd_deadline;
               end
            end
            if (cnt_ff == CntBits'(NumSlots)) begin
               cnt_in = '0;
               state_in = op_ff == OP_TICK ? S_TSEL : S_RESP;
               if (op_ff == OP_QUERY) begin
                  rid_in = '0; rlast_in = 1'b1; rst_in = ST_OK; rwait_in = '0;
                  if (!best_ok_in) rwait_in = '1;
                  else if (now_ff < bestd_in) rwait_in = bestd_in - now_ff;
               end
            end else begin
               cnt_in = cnt_ff + CntBits'(1);
            end
         end
         S_TSEL: begin
            if (out_free) begin
               if (!best_ok_ff) begin
                  if (nres_ff == '0) begin
                     rv_in = 1'b1; rst_in = ST_NONE; rid_in = '0;
                     rwait_in = '0; rlast_in = 1'b1;
                  end else begin
                     rv_in = 1'b1; rlast_in = 1'b1;
                  end
                  state_in = S_IDLE;
               end else begin
                  if (nres_ff != '0) begin
                     rv_in = 1'b1;
                  end
                  taken_in[best_ff] = 1'b1;
                  prev_in = best_ff;
                  state_in = S_TRD;
               end
            end
         end
         S_TRD: begin
            rd_addr = prev_ff;
            state_in = S_TOUT;
         end
         S_TOUT: begin
            rd_addr = prev_ff;
            if (out_free) begin
               if (cyclic_ff[prev_ff]) begin
                  wr_en = 1'b1; wr_addr = prev_ff;
                  wr_deadline = now_ff + TimeBits'(rd_period);
               end else begin
                  active_in[prev_ff] = 1'b0;
               end
               rst_in = ST_EXPIRED; rid_in = prev_ff; rwait_in = '0; rlast_in = 1'b0;
               nres_in = nres_ff + CntBits'(1);
               best_ok_in = 1'b0;
               if (nres_in == CntBits'(MaxResults)) begin
                  state_in = S_RESP; rlast_in = 1'b1;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; active_ff <= '0; cyclic_ff <= '0; now_ff <= '0;
         rv_ff <= 1'b0; taken_ff <= '0; cnt_ff <= '0; nres_ff <= '0;
         best_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in; active_ff <= active_in; cyclic_ff <= cyclic_in;
         now_ff <= now_in; rv_ff <= rv_in; taken_ff <= taken_in;
         cnt_ff <= cnt_in; nres_ff <= nres_in; best_ok_ff <= best_ok_in;
      end
      op_ff <= op_in; sel_ff <= sel_in; per_ff <= per_in; rep_ff <= rep_in;
      fnow_ff <= fnow_in; best_ff <= best_in; bestd_ff <= bestd_in;
      prev_ff <= prev_in; rst_ff <= rst_in; rid_ff <= rid_in;
      rwait_ff <= rwait_in; rlast_ff <= rlast_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rst_ff;
   assign rsp_slot_id = rid_ff;
   assign rsp_wait_ms = rwait_ff;
   assign rsp_last_item = rlast_ff;

   `DTT_ASSERT_IMP(a_stall_busy, clock, reset, state_ff != S_IDLE, req_stall)
   `DTT_ASSERT_NXT(a_hold, clock, reset, rv_ff && rsp_stall,
      rv_ff && $stable(rid_ff) && $stable(rst_ff))
   `DTT_ASSERT_IMP(a_exp_ok, clock, reset, rv_ff && rst_ff == ST_EXPIRED,
      active_ff[rid_ff] || !cyclic_ff[rid_ff])
endmodule
